// ----- rtl/cic_pkg.sv -----
// ----------------------------------------------------------------------------
// Cascaded interrupt controller package
// Shared types, codes and priority helpers for the master/slave controller.
// ----------------------------------------------------------------------------
package cic_pkg;

   // Item operation codes.
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_LINE  = 2'd2,
      OP_ACK   = 2'd3
   } op_type;

   // What a line event does to the line level.
   typedef enum logic [1:0] {
      LOP_DROP   = 2'd0,
      LOP_RAISE  = 2'd1,
      LOP_TOGGLE = 2'd2,
      LOP_PULSE  = 2'd3
   } line_op_type;

   // Per-controller action decoded from one item.
   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_CMD_WR  = 3'd1,
      ACT_DATA_WR = 3'd2,
      ACT_ELCR_WR = 3'd3,
      ACT_CMD_RD  = 3'd4,
      ACT_LINE    = 3'd5,
      ACT_ACK     = 3'd6
   } act_kind_type;

   // Bus port addresses.
   localparam logic [2:0] PORT_MASTER_CMD  = 3'd0;
   localparam logic [2:0] PORT_MASTER_DATA = 3'd1;
   localparam logic [2:0] PORT_SLAVE_CMD   = 3'd2;
   localparam logic [2:0] PORT_SLAVE_DATA  = 3'd3;
   localparam logic [2:0] PORT_MASTER_ELCR = 3'd4;
   localparam logic [2:0] PORT_SLAVE_ELCR  = 3'd5;

   // Initialisation sequence steps.
   localparam logic [2:0] INIT_NONE  = 3'd0;
   localparam logic [2:0] INIT_ICW2  = 3'd1;
   localparam logic [2:0] INIT_ICW3  = 3'd2;
   localparam logic [2:0] INIT_ICW4  = 3'd3;
   localparam logic [2:0] INIT_READY = 3'd4;

   // OCW2 command field (bits 7:5).
   localparam logic [2:0] OCW2_CLR_ROTAEOI = 3'd0;
   localparam logic [2:0] OCW2_EOI         = 3'd1;
   localparam logic [2:0] OCW2_NOP         = 3'd2;
   localparam logic [2:0] OCW2_SPEC_EOI    = 3'd3;
   localparam logic [2:0] OCW2_SET_ROTAEOI = 3'd4;
   localparam logic [2:0] OCW2_ROT_EOI     = 3'd5;
   localparam logic [2:0] OCW2_SET_PRIO    = 3'd6;
   localparam logic [2:0] OCW2_ROT_SPEC    = 3'd7;

   // Mode flag bit positions.
   localparam int unsigned FLAG_AEOI    = 0;
   localparam int unsigned FLAG_ROTAEOI = 1;
   localparam int unsigned FLAG_SMM     = 2;
   localparam int unsigned FLAG_POLL    = 3;
   localparam int unsigned FLAG_RSR     = 4;

   // Byte-level constants.
   localparam logic [7:0] PRIO_ENC_HI      = 8'hf0;
   localparam logic [7:0] PRIO_ENC_MID     = 8'hcc;
   localparam logic [7:0] PRIO_ENC_LO      = 8'haa;
   localparam logic [7:0] OCW2_SEL_MASK    = 8'h18;
   localparam logic [7:0] OCW3_SEL_MASK    = 8'h98;
   localparam logic [7:0] OCW3_SEL_CODE    = 8'h08;
   localparam logic [7:0] POLL_VALID_BIT   = 8'h80;
   localparam logic [7:0] VECTOR_BASE_MASK = 8'hf8;
   localparam logic [7:0] LINE_NUMBER_MAX  = 8'd15;
   localparam logic [2:0] LINE_CASCADE     = 3'd2;

   typedef struct packed {
      logic [7:0] lvl;
      logic [7:0] irr;
      logic [7:0] isr;
      logic [7:0] imr;
      logic [7:0] elcr;
      logic [2:0] init;
      logic [2:0] lp;
      logic [7:0] base;
      logic [4:0] flags;
   } ctl_state_type;

   typedef struct packed {
      act_kind_type kind;
      logic [7:0]   data;
      logic [2:0]   line;
      line_op_type  lop;
   } ctl_action_type;

   typedef struct packed {
      logic [7:0] cmd_rdata;
      logic       notify;
   } ctl_result_type;

   typedef struct packed {
      logic [7:0] mask;
      logic [2:0] idx;
   } pick_type;

   function automatic logic [7:0] rotr8(logic [7:0] v, logic [2:0] r);
      logic [15:0] d;
      d = {v, v} >> r;
      return d[7:0];
   endfunction

   function automatic logic [7:0] rotl8(logic [7:0] v, logic [2:0] r);
      logic [15:0] d;
      d = {v, v} << r;
      return d[15:8];
   endfunction

   // Highest-priority set bit of v, lp being the line of lowest priority.
   function automatic pick_type prio_pick(logic [7:0] v, logic [2:0] lp);
      logic [2:0] r;
      logic [7:0] x;
      pick_type   p;
      r = lp + 3'd1;
      x = rotr8(v, r);
      x = x & (~x + 8'd1);
      x = rotl8(x, r);
      p.mask = x;
      p.idx  = {|(x & PRIO_ENC_HI), |(x & PRIO_ENC_MID), |(x & PRIO_ENC_LO)};
      return p;
   endfunction

   // Winning request of one controller; in special mask mode with a mask
   // set, the in-service bits take no part in resolution.
   function automatic pick_type winner(ctl_state_type st);
      logic [7:0] s;
      pick_type   p;
      s = (st.flags[FLAG_SMM] && (st.imr != 8'd0)) ? 8'd0 : st.isr;
      p = prio_pick((st.irr & ~st.imr) | s, st.lp);
      p.mask = p.mask & ~s;
      return p;
   endfunction

   // Line level change and the request it raises. Level-triggered lines
   // request while low.
   function automatic ctl_state_type line_event(ctl_state_type st, logic [2:0] line_sel,
                                                line_op_type lop);
      ctl_state_type r;
      logic [7:0]    m;
      r = st;
      m = 8'b1 << line_sel;
      unique case (lop)
         LOP_DROP:              r.lvl = st.lvl & ~m;
         LOP_TOGGLE:            r.lvl = st.lvl ^ m;
         LOP_RAISE, LOP_PULSE:  r.lvl = st.lvl | m;
         default:               r.lvl = st.lvl;
      endcase
      if ((st.elcr & m) != 8'd0) begin
         r.irr = (st.irr & ~m) | (~r.lvl & m);
      end else begin
         r.irr = st.irr | (r.lvl & ~st.lvl & m);
         if (lop == LOP_PULSE) begin
            r.irr = r.irr | m;
         end
      end
      return r;
   endfunction

endpackage

// ----- rtl/cic_ctl.sv -----
// ----------------------------------------------------------------------------
// Controller next-state logic
// Applies one decoded action to the state of one 8259-style controller.
// ----------------------------------------------------------------------------
module cic_ctl
   import cic_pkg::*;
(
   input  ctl_state_type  state,
   input  ctl_action_type action,
   output ctl_state_type  state_next,
   output ctl_result_type result
);

   pick_type   win;
   pick_type   isr_pick;
   logic [7:0] cmd_byte;
   logic [7:0] cmd_mask;

   // Acknowledge of one line: move it from request to service, then
   // retire it at once in automatic EOI mode.
   function automatic ctl_state_type ack_line(ctl_state_type st, logic [2:0] b);
      ctl_state_type r;
      logic [7:0]    m;
      r = st;
      m = 8'b1 << b;
      r.irr = st.irr & ~m;
      r.isr = st.isr | m;
      if (st.flags[FLAG_AEOI]) begin
         r.isr = r.isr & ~m;
         if (st.flags[FLAG_ROTAEOI]) begin
            r.lp = b;
         end
      end
      return r;
   endfunction

   assign win      = winner(state);
   assign isr_pick = prio_pick(state.isr, state.lp);
   assign cmd_byte = action.data;
   assign cmd_mask = 8'b1 << cmd_byte[2:0];

   always_comb begin
      state_next = state;
      result     = '0;
      unique case (action.kind)
         ACT_CMD_WR: begin
            if (cmd_byte[4]) begin
               // ICW1 restarts the initialisation sequence.
               state_next.irr   = 8'd0;
               state_next.isr   = 8'd0;
               state_next.imr   = 8'd0;
               state_next.lp    = 3'd7;
               state_next.flags = 5'd0;
               state_next.init  = INIT_ICW2;
            end else if ((cmd_byte & OCW2_SEL_MASK) == 8'd0) begin
               result.notify = 1'b1;
               unique case (cmd_byte[7:5])
                  OCW2_CLR_ROTAEOI: state_next.flags[FLAG_ROTAEOI] = 1'b0;
                  OCW2_EOI:         state_next.isr = state.isr & ~isr_pick.mask;
                  OCW2_NOP:         state_next.isr = state.isr;
                  OCW2_SPEC_EOI:    state_next.isr = state.isr & ~cmd_mask;
                  OCW2_SET_ROTAEOI: state_next.flags[FLAG_ROTAEOI] = 1'b1;
                  OCW2_ROT_EOI: begin
                     state_next.isr = state.isr & ~isr_pick.mask;
                     state_next.lp  = isr_pick.idx;
                  end
                  OCW2_SET_PRIO:    state_next.lp = cmd_byte[2:0];
                  OCW2_ROT_SPEC: begin
                     state_next.isr = state.isr & ~cmd_mask;
                     state_next.lp  = cmd_byte[2:0];
                  end
                  default:          state_next.isr = state.isr;
               endcase
            end else if ((cmd_byte & OCW3_SEL_MASK) == OCW3_SEL_CODE) begin
               result.notify = 1'b1;
               if (cmd_byte[6]) begin
                  state_next.flags[FLAG_SMM] = cmd_byte[5];
               end
               if (cmd_byte[2]) begin
                  state_next.flags[FLAG_POLL] = 1'b1;
               end
               if (cmd_byte[1]) begin
                  state_next.flags[FLAG_RSR] = cmd_byte[0];
               end
            end
         end
         ACT_DATA_WR: begin
            unique case (state.init)
               INIT_ICW2: begin
                  state_next.base = cmd_byte;
                  state_next.init = INIT_ICW3;
               end
               INIT_ICW3: state_next.init = INIT_ICW4;
               INIT_ICW4: begin
                  if (cmd_byte[1]) begin
                     state_next.flags[FLAG_AEOI] = 1'b1;
                  end
                  state_next.init = INIT_READY;
                  result.notify   = 1'b1;
               end
               INIT_READY: begin
                  state_next.imr = cmd_byte;
                  result.notify  = 1'b1;
               end
               default: state_next.init = state.init;
            endcase
         end
         ACT_ELCR_WR: state_next.elcr = cmd_byte;
         ACT_CMD_RD: begin
            if (state.flags[FLAG_RSR]) begin
               result.cmd_rdata = state.isr;
            end else if (state.flags[FLAG_POLL]) begin
               // A poll read acknowledges the winner, if there is one.
               state_next.flags[FLAG_POLL] = 1'b0;
               if (win.mask != 8'd0) begin
                  state_next       = ack_line(state_next, win.idx);
                  result.cmd_rdata = POLL_VALID_BIT | {5'd0, win.idx};
                  result.notify    = 1'b1;
               end
            end else begin
               result.cmd_rdata = state.irr;
            end
         end
         ACT_LINE: begin
            state_next    = line_event(state, action.line, action.lop);
            result.notify = 1'b1;
         end
         ACT_ACK: begin
            state_next    = ack_line(state, action.line);
            result.notify = 1'b1;
         end
         ACT_NONE: state_next = state;
         default:  state_next = state;
      endcase
   end

endmodule

// ----- rtl/cic_resolve.sv -----
// ----------------------------------------------------------------------------
// Request and vector resolution
// Forms the interrupt request and vector from both controllers' state.
// ----------------------------------------------------------------------------
module cic_resolve
   import cic_pkg::*;
(
   input  ctl_state_type master,
   input  ctl_state_type slave,
   output logic          int_request,
   output logic [7:0]    int_vector
);

   pick_type master_win;
   pick_type slave_win;

   assign master_win = winner(master);
   assign slave_win  = winner(slave);

   always_comb begin
      int_request = 1'b0;
      int_vector  = 8'd0;
      if (master.init == INIT_READY) begin
         // The cascade line hands the choice over to the slave.
         if ((master_win.mask != 8'd0) && (master_win.idx == LINE_CASCADE)) begin
            int_request = (slave_win.mask != 8'd0);
            int_vector  = (slave.base & VECTOR_BASE_MASK) | {5'd0, slave_win.idx};
         end else begin
            int_request = (master_win.mask != 8'd0);
            int_vector  = (master.base & VECTOR_BASE_MASK) | {5'd0, master_win.idx};
         end
         if (!int_request) begin
            int_vector = 8'd0;
         end
      end
   end

endmodule

// ----- rtl/cascaded_interrupt_controller_top.sv -----
// ----------------------------------------------------------------------------
// Cascaded interrupt controller, top level
// Master and slave 8259-style controllers, slave cascaded on master line 2.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  operation, port_select, write_data,
//                                             line_or_vector, line_op
//   rsp_      out        rsp_valid/rsp_stall  read_data, int_request, int_vector,
//                                             ack_ignored
//
// Each item waits in the input register, where the whole update is worked
// out, and is then written to the result register and the state.
// A new item is taken every cycle while no result is held by rsp_stall.
// The input register waits only while a result is held by rsp_stall.
// Reset is synchronous and clears both controllers and both valid flags.
//
module cascaded_interrupt_controller_top
   import cic_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [2:0] req_port_select,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_line_or_vector,
   input  logic [1:0] req_line_op,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_int_request,
   output logic [7:0] rsp_int_vector,
   output logic       rsp_ack_ignored
);

   // Input register.
   logic          in_valid_ff, in_valid_in;
   op_type        in_op_ff;
   logic [2:0]    in_port_ff;
   logic [7:0]    in_wdata_ff;
   logic [7:0]    in_lov_ff;
   line_op_type   in_lop_ff;

   // Controller state.
   ctl_state_type master_ff, master_in;
   ctl_state_type slave_ff, slave_in;

   // Result register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_rdata_ff, rsp_rdata_in;
   logic          rsp_req_ff, rsp_req_in;
   logic [7:0]    rsp_vec_ff, rsp_vec_in;
   logic          rsp_ign_ff, rsp_ign_in;

   logic           req_accept;
   logic           advance;
   ctl_action_type master_act, slave_act;
   ctl_state_type  master_next, slave_next;
   ctl_result_type master_res, slave_res;
   pick_type       slave_win;
   logic           cascade_fire;
   logic           match_master, match_slave;

   // The item in the input register moves on whenever the result register
   // is empty or is being emptied in the same cycle.
   assign advance    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_op_ff    <= op_type'(req_operation);
         in_port_ff  <= req_port_select;
         in_wdata_ff <= req_write_data;
         in_lov_ff   <= req_line_or_vector;
         in_lop_ff   <= line_op_type'(req_line_op);
      end
   end

   // An acknowledge matches on the vector base with its low three bits
   // ignored; the master is tried first.
   assign match_master = (in_lov_ff & VECTOR_BASE_MASK) == (master_ff.base & VECTOR_BASE_MASK);
   assign match_slave  = (in_lov_ff & VECTOR_BASE_MASK) == (slave_ff.base & VECTOR_BASE_MASK);

   // Split the item into one action for each controller.
   always_comb begin
      master_act.kind = ACT_NONE;
      master_act.data = in_wdata_ff;
      master_act.line = in_lov_ff[2:0];
      master_act.lop  = in_lop_ff;
      slave_act       = master_act;
      rsp_ign_in      = 1'b0;
      unique case (in_op_ff)
         OP_WRITE: begin
            unique case (in_port_ff)
               PORT_MASTER_CMD:  master_act.kind = ACT_CMD_WR;
               PORT_MASTER_DATA: master_act.kind = ACT_DATA_WR;
               PORT_SLAVE_CMD:   slave_act.kind  = ACT_CMD_WR;
               PORT_SLAVE_DATA:  slave_act.kind  = ACT_DATA_WR;
               PORT_MASTER_ELCR: master_act.kind = ACT_ELCR_WR;
               PORT_SLAVE_ELCR:  slave_act.kind  = ACT_ELCR_WR;
               default:          master_act.kind = ACT_NONE;
            endcase
         end
         OP_READ: begin
            if (in_port_ff == PORT_MASTER_CMD) begin
               master_act.kind = ACT_CMD_RD;
            end else if (in_port_ff == PORT_SLAVE_CMD) begin
               slave_act.kind = ACT_CMD_RD;
            end
         end
         OP_LINE: begin
            // Lines 8 to 15 belong to the slave; higher numbers are dropped.
            if (in_lov_ff <= LINE_NUMBER_MAX) begin
               if (in_lov_ff[3]) begin
                  slave_act.kind = ACT_LINE;
               end else begin
                  master_act.kind = ACT_LINE;
               end
            end
         end
         OP_ACK: begin
            if (match_master) begin
               master_act.kind = ACT_ACK;
            end else if (match_slave) begin
               // A slave vector also acknowledges the cascade line.
               master_act.kind = ACT_ACK;
               master_act.line = LINE_CASCADE;
               slave_act.kind  = ACT_ACK;
            end else begin
               rsp_ign_in = 1'b1;
            end
         end
         default: rsp_ign_in = 1'b0;
      endcase
   end

   cic_ctl u_master (
      .state      (master_ff),
      .action     (master_act),
      .state_next (master_next),
      .result     (master_res)
   );

   cic_ctl u_slave (
      .state      (slave_ff),
      .action     (slave_act),
      .state_next (slave_next),
      .result     (slave_res)
   );

   // Once the slave is initialised, every update of it that sets notify drives
   // master line 2 high when it has a winner and low otherwise. This follows
   // whatever the master itself did for the same item.
   assign slave_win    = winner(slave_next);
   assign cascade_fire = slave_res.notify && (slave_next.init == INIT_READY);

   always_comb begin
      slave_in  = slave_next;
      master_in = master_next;
      if (cascade_fire) begin
         master_in = line_event(master_next, LINE_CASCADE,
                                (slave_win.mask != 8'd0) ? LOP_RAISE : LOP_DROP);
      end
   end

   // Read data comes from the state before the item, except for the
   // command ports, where a poll read has its own side effects.
   always_comb begin
      rsp_rdata_in = 8'd0;
      if (in_op_ff == OP_READ) begin
         unique case (in_port_ff)
            PORT_MASTER_CMD:  rsp_rdata_in = master_res.cmd_rdata;
            PORT_MASTER_DATA: rsp_rdata_in = master_ff.imr;
            PORT_SLAVE_CMD:   rsp_rdata_in = slave_res.cmd_rdata;
            PORT_SLAVE_DATA:  rsp_rdata_in = slave_ff.imr;
            PORT_MASTER_ELCR: rsp_rdata_in = master_ff.elcr;
            PORT_SLAVE_ELCR:  rsp_rdata_in = slave_ff.elcr;
            default:          rsp_rdata_in = 8'd0;
         endcase
      end
   end

   cic_resolve u_resolve (
      .master      (master_in),
      .slave       (slave_in),
      .int_request (rsp_req_in),
      .int_vector  (rsp_vec_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff    <= '0;
         slave_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            master_ff <= master_in;
            slave_ff  <= slave_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_rdata_ff <= rsp_rdata_in;
         rsp_req_ff   <= rsp_req_in;
         rsp_vec_ff   <= rsp_vec_in;
         rsp_ign_ff   <= rsp_ign_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_rdata_ff;
   assign rsp_int_request = rsp_req_ff;
   assign rsp_int_vector  = rsp_vec_ff;
   assign rsp_ack_ignored = rsp_ign_ff;

   // A vector is only ever shown together with a request.
   a_vector_needs_request : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_int_vector != 8'd0)) |-> rsp_int_request)
      else $error("vector shown without an interrupt request");

   // An item leaving the input register always produces a result.
   a_advance_gives_result : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("item advanced without a result");

   // Only an acknowledge can report an ignored vector.
   a_ignore_only_on_ack : assert property (@(posedge clock) disable iff (reset)
      (advance && (in_op_ff != OP_ACK)) |=> !rsp_ack_ignored)
      else $error("ack_ignored set for an item that is not an acknowledge");

   // Read data stays zero for anything but a bus read.
   a_rdata_only_on_read : assert property (@(posedge clock) disable iff (reset)
      (advance && (in_op_ff != OP_READ)) |=> (rsp_read_data == 8'd0))
      else $error("read data nonzero for an item that is not a read");

endmodule

// ----- tb/cascaded_interrupt_controller_top_test.sv -----
// ----------------------------------------------------------------------------
// Cascaded interrupt controller testbench
// Drives bus accesses, line events and acknowledges into the master/slave
// pair and checks every response against a cycle-free behavioural model.
// ----------------------------------------------------------------------------
module cascaded_interrupt_controller_top_test
   import cic_pkg::*;
();

   // One request item as the driver presents it. The two trailing flags are
   // for the driver only: wait_for_drain holds the item back until every
   // outstanding response has come, and calm switches idling off on both
   // channels while the item is in flight.
   typedef struct packed {
      op_type      operation;
      logic [2:0]  port_select;
      logic [7:0]  write_data;
      logic [7:0]  line_or_vector;
      line_op_type line_op;
      logic        wait_for_drain;
      logic        calm;
   } pic_item_type;

   // One response item.
   typedef struct packed {
      logic [7:0] read_data;
      logic       int_request;
      logic [7:0] int_vector;
      logic       ack_ignored;
   } pic_response_type;

   localparam int unsigned RANDOM_ITEMS = 450;
   localparam int unsigned CALM_FIRST   = 150;
   localparam int unsigned CALM_LAST    = 230;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   op_type      req_operation = OP_WRITE;
   logic [2:0]  req_port_select = 3'd0;
   logic [7:0]  req_write_data = 8'd0;
   logic [7:0]  req_line_or_vector = 8'd0;
   line_op_type req_line_op = LOP_DROP;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        rsp_int_request;
   logic [7:0]  rsp_int_vector;
   logic        rsp_ack_ignored;

   cascaded_interrupt_controller_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_port_select    (req_port_select),
      .req_write_data     (req_write_data),
      .req_line_or_vector (req_line_or_vector),
      .req_line_op        (req_line_op),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .rsp_int_request    (rsp_int_request),
      .rsp_int_vector     (rsp_int_vector),
      .rsp_ack_ignored    (rsp_ack_ignored)
   );

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // Behavioural model of both controllers. Index 0 is the master (lines 0 to
   // 7) and index 1 the slave (lines 8 to 15), which sits on master line 2.
   // -------------------------------------------------------------------------
   logic [7:0] ctl_lines   [2];
   logic [7:0] ctl_irr     [2];
   logic [7:0] ctl_isr     [2];
   logic [7:0] ctl_imr     [2];
   logic [7:0] ctl_elcr    [2];
   logic [7:0] ctl_base    [2];
   logic [2:0] ctl_init    [2];
   logic [2:0] ctl_lowest  [2];
   logic [4:0] ctl_flags   [2];

   // Finds the set bit of v with the highest priority. The line just after
   // 'lowest' has the top priority and 'lowest' itself comes last. An empty
   // v gives an empty mask and line zero.
   function automatic logic [7:0] top_priority(logic [7:0] v, logic [2:0] lowest,
                                               output logic [2:0] line_no);
      logic [7:0] hit;
      logic [2:0] cand;
      int         k;
      hit     = 8'd0;
      line_no = 3'd0;
      for (k = 1; k <= 8; k++) begin
         cand = lowest + 3'(k);
         if (hit == 8'd0 && v[cand]) begin
            hit     = 8'd1 << cand;
            line_no = cand;
         end
      end
      return hit;
   endfunction

   // The request that would be serviced next. A higher-priority line in
   // service blocks everything below it, except in special mask mode with a
   // mask set, where the in-service bits are left out altogether.
   function automatic logic [7:0] winning_request(int c, output logic [2:0] line_no);
      logic [7:0] svc;
      logic [7:0] hit;
      svc = (ctl_flags[c][FLAG_SMM] && ctl_imr[c] != 8'd0) ? 8'd0 : ctl_isr[c];
      hit = top_priority((ctl_irr[c] & ~ctl_imr[c]) | svc, ctl_lowest[c], line_no);
      return hit & ~svc;
   endfunction

   // Level change on one line. Edge lines latch a request on a rising level;
   // level lines request while they are low.
   function automatic void set_line(int c, logic [2:0] line_no, line_op_type lop);
      logic [7:0] bit_mask;
      logic [7:0] prev;
      bit_mask = 8'd1 << line_no;
      prev     = ctl_lines[c];
      case (lop)
         LOP_DROP:   ctl_lines[c] = prev & ~bit_mask;
         LOP_TOGGLE: ctl_lines[c] = prev ^ bit_mask;
         default:    ctl_lines[c] = prev | bit_mask;
      endcase
      if ((ctl_elcr[c] & bit_mask) != 8'd0) begin
         ctl_irr[c] = (ctl_irr[c] & ~bit_mask) | (~ctl_lines[c] & bit_mask);
      end else begin
         ctl_irr[c] = ctl_irr[c] | (ctl_lines[c] & ~prev & bit_mask);
         if (lop == LOP_PULSE) begin
            ctl_irr[c] = ctl_irr[c] | bit_mask;
         end
      end
   endfunction

   // A ready slave reflects its pending request on master line 2 after every
   // change of its state other than an ELCR write.
   function automatic void follow_cascade(int c);
      logic [2:0] line_no;
      logic [7:0] hit;
      if (c == 1 && ctl_init[1] == INIT_READY) begin
         hit = winning_request(1, line_no);
         set_line(0, LINE_CASCADE, (hit != 8'd0) ? LOP_RAISE : LOP_DROP);
      end
   endfunction

   function automatic void acknowledge_line(int c, logic [2:0] line_no);
      logic [7:0] bit_mask;
      bit_mask   = 8'd1 << line_no;
      ctl_irr[c] = ctl_irr[c] & ~bit_mask;
      ctl_isr[c] = ctl_isr[c] | bit_mask;
      if (ctl_flags[c][FLAG_AEOI]) begin
         ctl_isr[c] = ctl_isr[c] & ~bit_mask;
         if (ctl_flags[c][FLAG_ROTAEOI]) begin
            ctl_lowest[c] = line_no;
         end
      end
      follow_cascade(c);
   endfunction

   function automatic void write_command(int c, logic [7:0] v);
      logic [7:0] bit_mask;
      logic [7:0] hit;
      logic [2:0] line_no;
      bit_mask = 8'd1 << v[2:0];
      if (v[4]) begin
         // ICW1 starts the initialisation sequence over.
         ctl_irr[c]    = 8'd0;
         ctl_isr[c]    = 8'd0;
         ctl_imr[c]    = 8'd0;
         ctl_lowest[c] = 3'd7;
         ctl_flags[c]  = 5'd0;
         ctl_init[c]   = INIT_ICW2;
      end else if ((v & OCW2_SEL_MASK) == 8'd0) begin
         case (v[7:5])
            OCW2_CLR_ROTAEOI: ctl_flags[c][FLAG_ROTAEOI] = 1'b0;
            OCW2_EOI: begin
               hit        = top_priority(ctl_isr[c], ctl_lowest[c], line_no);
               ctl_isr[c] = ctl_isr[c] & ~hit;
            end
            OCW2_SPEC_EOI:    ctl_isr[c] = ctl_isr[c] & ~bit_mask;
            OCW2_SET_ROTAEOI: ctl_flags[c][FLAG_ROTAEOI] = 1'b1;
            OCW2_ROT_EOI: begin
               // With nothing in service the lowest priority falls to line 0.
               hit           = top_priority(ctl_isr[c], ctl_lowest[c], line_no);
               ctl_isr[c]    = ctl_isr[c] & ~hit;
               ctl_lowest[c] = line_no;
            end
            OCW2_SET_PRIO: ctl_lowest[c] = v[2:0];
            OCW2_ROT_SPEC: begin
               ctl_isr[c]    = ctl_isr[c] & ~bit_mask;
               ctl_lowest[c] = v[2:0];
            end
            default: ;
         endcase
         follow_cascade(c);
      end else if ((v & OCW3_SEL_MASK) == OCW3_SEL_CODE) begin
         if (v[6]) begin
            ctl_flags[c][FLAG_SMM] = v[5];
         end
         if (v[2]) begin
            ctl_flags[c][FLAG_POLL] = 1'b1;
         end
         if (v[1]) begin
            ctl_flags[c][FLAG_RSR] = v[0];
         end
         follow_cascade(c);
      end
   endfunction

   function automatic void write_data_port(int c, logic [7:0] v);
      case (ctl_init[c])
         INIT_ICW2: begin
            ctl_base[c] = v;
            ctl_init[c] = INIT_ICW3;
         end
         INIT_ICW3: ctl_init[c] = INIT_ICW4;
         INIT_ICW4: begin
            if (v[1]) begin
               ctl_flags[c][FLAG_AEOI] = 1'b1;
            end
            ctl_init[c] = INIT_READY;
            follow_cascade(c);
         end
         INIT_READY: begin
            ctl_imr[c] = v;
            follow_cascade(c);
         end
         default: ;
      endcase
   endfunction

   // Command port read: the in-service select wins over a pending poll, and
   // a poll acknowledges the winning line as an interrupt cycle would.
   function automatic logic [7:0] read_command(int c);
      logic [7:0] hit;
      logic [7:0] value;
      logic [2:0] line_no;
      value = ctl_irr[c];
      if (ctl_flags[c][FLAG_RSR]) begin
         value = ctl_isr[c];
      end else if (ctl_flags[c][FLAG_POLL]) begin
         ctl_flags[c][FLAG_POLL] = 1'b0;
         hit   = winning_request(c, line_no);
         value = 8'd0;
         if (hit != 8'd0) begin
            acknowledge_line(c, line_no);
            value = POLL_VALID_BIT | {5'd0, line_no};
         end
      end
      return value;
   endfunction

   // Applies one item to the model and works out the response it causes.
   function automatic pic_response_type predict_response(pic_item_type it);
      pic_response_type rsp;
      logic [7:0]       hit;
      logic [2:0]       line_no;
      logic [7:0]       vec_hi;
      int               c;
      rsp = '0;
      c   = int'(it.port_select[1]);
      vec_hi = it.line_or_vector & VECTOR_BASE_MASK;
      case (it.operation)
         OP_WRITE: begin
            if (it.port_select <= PORT_SLAVE_DATA) begin
               if (it.port_select[0]) begin
                  write_data_port(c, it.write_data);
               end else begin
                  write_command(c, it.write_data);
               end
            end else if (it.port_select <= PORT_SLAVE_ELCR) begin
               ctl_elcr[it.port_select[0]] = it.write_data;
            end
         end
         OP_READ: begin
            if (it.port_select <= PORT_SLAVE_DATA) begin
               rsp.read_data = it.port_select[0] ? ctl_imr[c] : read_command(c);
            end else if (it.port_select <= PORT_SLAVE_ELCR) begin
               rsp.read_data = ctl_elcr[it.port_select[0]];
            end
         end
         OP_LINE: begin
            if (it.line_or_vector <= LINE_NUMBER_MAX) begin
               set_line(int'(it.line_or_vector[3]), it.line_or_vector[2:0], it.line_op);
               follow_cascade(int'(it.line_or_vector[3]));
            end
         end
         default: begin
            if (vec_hi == (ctl_base[0] & VECTOR_BASE_MASK)) begin
               acknowledge_line(0, it.line_or_vector[2:0]);
            end else if (vec_hi == (ctl_base[1] & VECTOR_BASE_MASK)) begin
               acknowledge_line(0, LINE_CASCADE);
               acknowledge_line(1, it.line_or_vector[2:0]);
            end else begin
               rsp.ack_ignored = 1'b1;
            end
         end
      endcase
      if (ctl_init[0] == INIT_READY) begin
         hit = winning_request(0, line_no);
         if (hit != 8'd0 && line_no == LINE_CASCADE) begin
            hit            = winning_request(1, line_no);
            rsp.int_vector = (ctl_base[1] & VECTOR_BASE_MASK) | {5'd0, line_no};
         end else begin
            rsp.int_vector = (ctl_base[0] & VECTOR_BASE_MASK) | {5'd0, line_no};
         end
         if (hit != 8'd0) begin
            rsp.int_request = 1'b1;
         end else begin
            rsp.int_vector = 8'd0;
         end
      end
      return rsp;
   endfunction

   // -------------------------------------------------------------------------
   // Shared bookkeeping.
   // -------------------------------------------------------------------------
   pic_item_type     pending_items[$];
   pic_response_type expected_responses[$];
   pic_item_type     driven_item;
   pic_response_type oldest_response;
   int unsigned      items_accepted = 0;
   int unsigned      responses_seen = 0;
   int unsigned      mismatches = 0;
   int unsigned      gap_left = 0;
   int unsigned      stall_left = 0;
   logic             calm_phase = 1'b0;
   bit               took_item;

   // Idle stretches: mostly none or a few cycles, now and then a long one.
   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 30);
   endfunction

   task automatic report_failure(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
   endtask

   task automatic check_field(string field, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
         report_failure($sformatf("response %0d: %s is 0x%02h, expected 0x%02h",
                                  responses_seen, field, got, want));
      end
   endtask

   function automatic void queue_item(op_type op, logic [2:0] port, logic [7:0] wd,
                                      logic [7:0] lv, line_op_type lop,
                                      bit drain, bit calm);
      pic_item_type it;
      it.operation      = op;
      it.port_select    = port;
      it.write_data     = wd;
      it.line_or_vector = lv;
      it.line_op        = lop;
      it.wait_for_drain = drain;
      it.calm           = calm;
      pending_items.push_back(it);
   endfunction

   // -------------------------------------------------------------------------
   // Driver. The model is updated at the edge where an item is taken, so the
   // expectations line up with the order in which the block sees the items.
   // A new item is only put on the port when the previous one has gone, so
   // valid is never lowered and raised in the same step.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         took_item = req_valid && !req_stall;
         if (took_item) begin
            expected_responses.push_back(predict_response(driven_item));
            items_accepted <= items_accepted + 1;
         end
         if (!req_valid || took_item) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0 &&
                         !(pending_items[0].wait_for_drain &&
                           (took_item || items_accepted != responses_seen))) begin
               driven_item = pending_items.pop_front();
               req_operation      <= driven_item.operation;
               req_port_select    <= driven_item.port_select;
               req_write_data     <= driven_item.write_data;
               req_line_or_vector <= driven_item.line_or_vector;
               req_line_op        <= driven_item.line_op;
               req_valid          <= 1'b1;
               calm_phase         <= driven_item.calm;
               gap_left = driven_item.calm ? 0 : idle_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor. A response is taken where valid is high and our own stall was
   // low before the edge; the stall for the next cycle is chosen afterwards.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               report_failure($sformatf("response %0d arrived with nothing expected",
                                        responses_seen));
            end else begin
               oldest_response = expected_responses.pop_front();
               check_field("read_data", rsp_read_data, oldest_response.read_data);
               check_field("int_request", {7'd0, rsp_int_request},
                           {7'd0, oldest_response.int_request});
               check_field("int_vector", rsp_int_vector, oldest_response.int_vector);
               check_field("ack_ignored", {7'd0, rsp_ack_ignored},
                           {7'd0, oldest_response.ack_ignored});
            end
            responses_seen <= responses_seen + 1;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = calm_phase ? 0 : idle_length();
            rsp_stall <= (stall_left != 0);
            if (stall_left != 0) begin
               stall_left--;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run.
   // -------------------------------------------------------------------------
   initial begin
      pic_item_type it;
      logic [7:0]   gen_base [2];
      logic [7:0]   new_base;
      int unsigned  produced;
      int unsigned  choice;
      int unsigned  kind;
      int           c;
      bit           drain;
      bit           calm;

      for (c = 0; c < 2; c++) begin
         ctl_lines[c]  = 8'd0;
         ctl_irr[c]    = 8'd0;
         ctl_isr[c]    = 8'd0;
         ctl_imr[c]    = 8'd0;
         ctl_elcr[c]   = 8'd0;
         ctl_base[c]   = 8'd0;
         ctl_init[c]   = INIT_NONE;
         ctl_lowest[c] = 3'd0;
         ctl_flags[c]  = 5'd0;
      end

      // Directed part. Before initialisation: a read, an ignored data write
      // and a line number out of range.
      queue_item(OP_READ,  PORT_MASTER_CMD,  8'hff, 8'hff, LOP_PULSE,  0, 0);
      queue_item(OP_WRITE, PORT_MASTER_DATA, 8'hff, 8'h00, LOP_DROP,   0, 0);
      queue_item(OP_LINE,  PORT_MASTER_CMD,  8'h00, 8'hff, LOP_PULSE,  0, 0);
      // Master at base 0x20 (the low bits of ICW2 are dropped), slave at 0x70
      // with automatic EOI.
      queue_item(OP_WRITE, PORT_MASTER_CMD,  8'h11, 8'h00, LOP_RAISE,  0, 0);
      queue_item(OP_WRITE, PORT_MASTER_DATA, 8'h27, 8'h00, LOP_RAISE,  0, 0);
      queue_item(OP_WRITE, PORT_MASTER_DATA, 8'h04, 8'h00, LOP_RAISE,  0, 0);
      queue_item(OP_WRITE, PORT_MASTER_DATA, 8'h01, 8'h00, LOP_RAISE,  0, 0);
      queue_item(OP_WRITE, PORT_SLAVE_CMD,   8'h11, 8'h00, LOP_TOGGLE, 0, 0);
      queue_item(OP_WRITE, PORT_SLAVE_DATA,  8'h70, 8'h00, LOP_TOGGLE, 0, 0);
      queue_item(OP_WRITE, PORT_SLAVE_DATA,  8'h02, 8'h00, LOP_TOGGLE, 0, 0);
      queue_item(OP_WRITE, PORT_SLAVE_DATA,  8'h03, 8'h00, LOP_TOGGLE, 0, 0);
      // Line 15 level-triggered, so dropping it raises a slave request that
      // is carried up the cascade line.
      queue_item(OP_WRITE, PORT_SLAVE_ELCR,  8'h80, 8'h00, LOP_DROP,   0, 0);
      queue_item(OP_LINE,  PORT_MASTER_CMD,  8'h00, 8'd0,  LOP_RAISE,  0, 0);
      queue_item(OP_LINE,  PORT_MASTER_CMD,  8'h00, 8'd15, LOP_DROP,   0, 0);
      queue_item(OP_ACK,   PORT_MASTER_CMD,  8'h00, 8'h20, LOP_DROP,   0, 0);
      // In-service select set, then a poll: the in-service read still wins.
      queue_item(OP_WRITE, PORT_MASTER_CMD,  8'h0b, 8'h00, LOP_DROP,   0, 0);
      queue_item(OP_WRITE, PORT_MASTER_CMD,  8'h0c, 8'h00, LOP_DROP,   0, 0);
      queue_item(OP_READ,  PORT_MASTER_CMD,  8'h00, 8'h00, LOP_DROP,   0, 0);
      queue_item(OP_WRITE, PORT_MASTER_CMD,  8'h60, 8'h00, LOP_DROP,   0, 0);
      queue_item(OP_ACK,   PORT_MASTER_CMD,  8'h00, 8'h77, LOP_DROP,   0, 0);
      // Rotating EOI twice: the second finds nothing in service.
      queue_item(OP_WRITE, PORT_MASTER_CMD,  8'ha0, 8'h00, LOP_DROP,   0, 0);
      queue_item(OP_WRITE, PORT_MASTER_CMD,  8'ha0, 8'h00, LOP_DROP,   0, 0);
      queue_item(OP_ACK,   PORT_MASTER_CMD,  8'h00, 8'hff, LOP_DROP,   0, 0);
      queue_item(OP_WRITE, PORT_MASTER_CMD,  8'h88, 8'h00, LOP_DROP,   0, 0);
      // Slave poll with a winner, then a poll with nothing pending.
      queue_item(OP_WRITE, PORT_SLAVE_CMD,   8'h0c, 8'h00, LOP_DROP,   0, 0);
      queue_item(OP_LINE,  PORT_MASTER_CMD,  8'h00, 8'd9,  LOP_TOGGLE, 0, 0);
      queue_item(OP_READ,  PORT_SLAVE_CMD,   8'h00, 8'h00, LOP_DROP,   0, 0);
      queue_item(OP_WRITE, PORT_SLAVE_CMD,   8'h0c, 8'h00, LOP_DROP,   0, 0);
      queue_item(OP_READ,  PORT_SLAVE_CMD,   8'h00, 8'h00, LOP_DROP,   0, 0);
      // Special mask mode with a mask set, then the unused ports.
      queue_item(OP_WRITE, PORT_MASTER_DATA, 8'h01, 8'h00, LOP_DROP,   0, 0);
      queue_item(OP_WRITE, PORT_MASTER_CMD,  8'h68, 8'h00, LOP_DROP,   0, 0);
      queue_item(OP_WRITE, 3'd6,             8'hff, 8'h00, LOP_DROP,   0, 0);
      queue_item(OP_READ,  3'd7,             8'h00, 8'h00, LOP_DROP,   0, 0);
      gen_base[0] = 8'h20;
      gen_base[1] = 8'h70;

      // Random part. Most items are well formed: line events on real lines,
      // acknowledges at a current base and command bytes that decode as OCW2
      // or OCW3. Now and then a controller is initialised afresh, and a small
      // share of raw bytes and stray vectors stays in as noise.
      produced = 0;
      while (produced < RANDOM_ITEMS) begin
         choice = $urandom_range(0, 99);
         drain  = (produced == 0) || ($urandom_range(0, 49) == 0);
         calm   = (produced >= CALM_FIRST) && (produced < CALM_LAST);
         if (choice < 4) begin
            c        = $urandom_range(0, 1);
            new_base = 8'($urandom);
            queue_item(OP_WRITE, (c == 1) ? PORT_SLAVE_CMD : PORT_MASTER_CMD,
                       8'($urandom) | 8'h10, 8'($urandom),
                       line_op_type'($urandom_range(0, 3)), drain, calm);
            queue_item(OP_WRITE, (c == 1) ? PORT_SLAVE_DATA : PORT_MASTER_DATA,
                       new_base, 8'($urandom), line_op_type'($urandom_range(0, 3)),
                       0, calm);
            queue_item(OP_WRITE, (c == 1) ? PORT_SLAVE_DATA : PORT_MASTER_DATA,
                       8'($urandom), 8'($urandom), line_op_type'($urandom_range(0, 3)),
                       0, calm);
            queue_item(OP_WRITE, (c == 1) ? PORT_SLAVE_DATA : PORT_MASTER_DATA,
                       8'($urandom), 8'($urandom), line_op_type'($urandom_range(0, 3)),
                       0, calm);
            gen_base[c] = new_base;
            produced += 4;
         end else begin
            it = pic_item_type'(25'($urandom));
            it.wait_for_drain = drain;
            it.calm           = calm;
            if (choice < 40) begin
               it.operation      = OP_LINE;
               it.line_or_vector = ($urandom_range(0, 31) == 0) ?
                                   8'($urandom_range(16, 255)) : 8'($urandom_range(0, 15));
            end else if (choice < 55) begin
               it.operation = OP_ACK;
               if ($urandom_range(0, 3) != 0) begin
                  it.line_or_vector = (gen_base[$urandom_range(0, 1)] & VECTOR_BASE_MASK) |
                                      8'($urandom_range(0, 7));
               end
            end else if (choice < 78) begin
               it.operation   = OP_WRITE;
               it.port_select = 3'($urandom_range(0, 7));
               kind = $urandom_range(0, 19);
               if (it.port_select == PORT_MASTER_CMD || it.port_select == PORT_SLAVE_CMD) begin
                  if (kind < 9) begin
                     it.write_data[4:3] = 2'b00;
                  end else if (kind < 18) begin
                     it.write_data[7]   = 1'b0;
                     it.write_data[4:3] = 2'b01;
                  end
               end else if (kind < 10) begin
                  // Sparse masks and select bytes leave more lines live.
                  it.write_data = it.write_data & 8'($urandom);
               end
            end else begin
               it.operation   = OP_READ;
               it.port_select = 3'($urandom_range(0, 7));
            end
            pending_items.push_back(it);
            produced++;
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Sampled on the falling edge, clear of the updates at the rising one.
      @(negedge clock);
      while (pending_items.size() != 0 || req_valid || items_accepted != responses_seen) begin
         @(negedge clock);
      end
      repeat (5) @(negedge clock);
      if (expected_responses.size() != 0) begin
         report_failure($sformatf("%0d responses never arrived", expected_responses.size()));
      end
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
